[rtl/core/sig_pkg.sv]
// Package for the sphere index generator: widths, section codes, register defaults.
package sig_pkg;

    localparam int DIV_W   = 8;
    localparam int IDX_W   = 16;
    localparam int SEC_W   = 2;

    localparam logic [DIV_W-1:0] DIV_RESET = 8'd16;
    localparam logic [DIV_W-1:0] DIV_MIN   = 8'd2;

    localparam logic [SEC_W-1:0] SEC_TOP    = 2'd0;
    localparam logic [SEC_W-1:0] SEC_MIDDLE = 2'd1;
    localparam logic [SEC_W-1:0] SEC_BOTTOM = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0] third_index;
        logic [IDX_W-1:0] second_index;
        logic [IDX_W-1:0] first_index;
    } tri_t;

endpackage

[rtl/core/sphere_index_generator_unit.sv]
// Sphere index generator: emits one triangle of a latitude-longitude sphere per request.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+------------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready   | tdata[0] restart
//  m_axis   | out | m_axis_tvalid/tready   | tdata first/second/third index, tlast last
//  cfg      | in  | cfg_valid/cfg_ready    | cfg_data divisions
//
// One triangle per cycle: the position counters and four 16-bit adders feed the
// result register directly, so a request is taken every cycle while the result
// register is empty or being drained. A result is valid in the cycle after its request is accepted.
// rst_n clears the position to the first top-cap triangle and divisions to 16.
// A stalled m_axis holds the result register and s_axis_tready drops.
// A divisions write also returns the position to the first triangle.
module sphere_index_generator_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] first_index, [31:16] second_index,
                                        // [47:32] third_index
    output logic        m_axis_tlast,   // last_triangle
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data        // divisions
);

    logic [sig_pkg::DIV_W-1:0] div_reg;
    logic [sig_pkg::SEC_W-1:0] sec_reg, sec_next;
    logic [sig_pkg::DIV_W-1:0] row_reg, row_next;
    logic [sig_pkg::DIV_W-1:0] col_reg, col_next;
    logic                      half_reg, half_next;
    logic [sig_pkg::IDX_W-1:0] base_reg, base_next;

    logic                      out_valid_reg;
    sig_pkg::tri_t             tri_reg, tri_next;
    logic                      last_reg, last_next;

    logic                      accept;
    logic [sig_pkg::DIV_W-1:0] d_eff;
    logic [sig_pkg::DIV_W:0]   n;
    logic [sig_pkg::SEC_W-1:0] sec_cur;
    logic [sig_pkg::DIV_W-1:0] row_cur;
    logic [sig_pkg::DIV_W-1:0] col_cur;
    logic                      half_cur;
    logic [sig_pkg::IDX_W-1:0] base_cur;
    logic [sig_pkg::IDX_W-1:0] idx_base;
    logic [sig_pkg::IDX_W-1:0] idx_next;
    logic [sig_pkg::DIV_W:0]   col_inc;
    logic                      col_wrap;
    logic [sig_pkg::DIV_W-1:0] row_inc;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = tri_reg;
    assign m_axis_tlast  = last_reg;

    assign d_eff = (div_reg < sig_pkg::DIV_MIN) ? sig_pkg::DIV_MIN : div_reg;
    assign n     = {1'b0, d_eff} + 9'd1;

    // restart forces the first top-cap position
    always_comb
    begin
        if (s_axis_tdata[0])
        begin
            sec_cur  = sig_pkg::SEC_TOP;
            row_cur  = '0;
            col_cur  = '0;
            half_cur = 1'b0;
            base_cur = '0;
        end
        else
        begin
            sec_cur  = sec_reg;
            row_cur  = row_reg;
            col_cur  = col_reg;
            half_cur = half_reg;
            base_cur = base_reg;
        end
    end

    assign idx_base = base_cur + {8'd0, col_cur};
    assign idx_next = idx_base + {7'd0, n};
    assign col_inc  = {1'b0, col_cur} + 9'd1;
    assign col_wrap = (col_inc == {1'b0, d_eff});
    assign row_inc  = row_cur + 8'd1;

    always_comb
    begin
        tri_next.first_index = idx_base;
        if (sec_cur == sig_pkg::SEC_BOTTOM || (sec_cur == sig_pkg::SEC_MIDDLE && half_cur))
        begin
            tri_next.second_index = idx_base + 16'd1;
            tri_next.third_index  = idx_next + 16'd1;
        end
        else
        begin
            tri_next.second_index = idx_next + 16'd1;
            tri_next.third_index  = idx_next;
        end
        last_next = (sec_cur == sig_pkg::SEC_BOTTOM) && col_wrap;
    end

    always_comb
    begin
        sec_next  = sec_cur;
        row_next  = row_cur;
        col_next  = col_cur;
        half_next = half_cur;
        base_next = base_cur;
        unique case (sec_cur)
            sig_pkg::SEC_TOP:
            begin
                col_next = col_inc[sig_pkg::DIV_W-1:0];
                if (col_wrap)
                begin
                    // first middle row, or the bottom row when divisions is 2 or less
                    col_next  = '0;
                    row_next  = 8'd1;
                    base_next = {7'd0, n};
                    sec_next  = (d_eff > sig_pkg::DIV_MIN) ? sig_pkg::SEC_MIDDLE
                                                           : sig_pkg::SEC_BOTTOM;
                end
            end
            sig_pkg::SEC_MIDDLE:
            begin
                if (!half_cur)
                begin
                    half_next = 1'b1;
                end
                else
                begin
                    half_next = 1'b0;
                    col_next  = col_inc[sig_pkg::DIV_W-1:0];
                    if (col_wrap)
                    begin
                        col_next  = '0;
                        row_next  = row_inc;
                        base_next = base_cur + {7'd0, n};
                        if ({1'b0, row_inc} + 9'd1 == {1'b0, d_eff})
                        begin
                            sec_next = sig_pkg::SEC_BOTTOM;
                        end
                    end
                end
            end
            default:
            begin
                col_next = col_inc[sig_pkg::DIV_W-1:0];
                if (col_wrap)
                begin
                    sec_next  = sig_pkg::SEC_TOP;
                    row_next  = '0;
                    col_next  = '0;
                    half_next = 1'b0;
                    base_next = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg       <= sig_pkg::DIV_RESET;
            sec_reg       <= sig_pkg::SEC_TOP;
            row_reg       <= '0;
            col_reg       <= '0;
            half_reg      <= 1'b0;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                div_reg  <= cfg_data;
                sec_reg  <= sig_pkg::SEC_TOP;
                row_reg  <= '0;
                col_reg  <= '0;
                half_reg <= 1'b0;
                base_reg <= '0;
            end
            else if (accept)
            begin
                sec_reg  <= sec_next;
                row_reg  <= row_next;
                col_reg  <= col_next;
                half_reg <= half_next;
                base_reg <= base_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tri_reg  <= tri_next;
            last_reg <= last_next;
        end
    end

endmodule

[tb/tb_sphere_index_generator_unit.sv]
// Testbench for sphere_index_generator_unit: predicts each triangle of the sweep and checks it.
module tb_sphere_index_generator_unit;

    import sig_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        tri_t corners;
        bit   last;
    } triangle_t;

    class triangle_scoreboard;
        logic [DIV_W-1:0] div_reg;
        logic [SEC_W-1:0] section;
        logic [7:0]       row;
        logic [7:0]       column;
        bit               second_half;
        logic [IDX_W-1:0] row_base;
        triangle_t        pending_triangles[$];
        int               checked;
        int               errors;
        int               sweeps;
        int unsigned      top_index;

        function new();
            div_reg = DIV_RESET;
            go_home();
        endfunction

        function void go_home();
            section     = SEC_TOP;
            row         = 8'd0;
            column      = 8'd0;
            second_half = 1'b0;
            row_base    = '0;
        endfunction

        function void set_divisions(logic [DIV_W-1:0] value);
            div_reg = value;
            go_home();
        endfunction

        function bit idle();
            return pending_triangles.size() == 0;
        endfunction

        function bit position_ok(int unsigned d);
            int unsigned n;
            n = d + 1;
            if (column >= d) return 1'b0;
            if (section == SEC_TOP)
                return row == 0 && row_base == 0 && !second_half;
            if (section == SEC_MIDDLE)
                return row >= 1 && row + 1 < d && row_base == row * n;
            if (section == SEC_BOTTOM)
                return row == d - 1 && row_base == row * n && !second_half;
            return 1'b0;
        endfunction

        // Predict the triangle for one accepted request, then advance the sweep.
        function void note_request(bit restart);
            int unsigned d;
            int unsigned n;
            int unsigned base;
            int unsigned nxt;
            triangle_t   t;
            d = (div_reg < DIV_MIN) ? DIV_MIN : div_reg;
            n = d + 1;
            if (restart || !position_ok(d))
                go_home();
            base = row_base + column;
            nxt  = base + n;
            t.last = 1'b0;
            t.corners.first_index = base[IDX_W-1:0];
            if (section == SEC_BOTTOM || (section == SEC_MIDDLE && second_half))
            begin
                t.corners.second_index = IDX_W'(base + 1);
                t.corners.third_index  = IDX_W'(nxt + 1);
                t.last = (section == SEC_BOTTOM) && (column + 1 == d);
            end
            else
            begin
                t.corners.second_index = IDX_W'(nxt + 1);
                t.corners.third_index  = IDX_W'(nxt);
            end
            pending_triangles.insert(pending_triangles.size(), t);

            if (section == SEC_TOP)
            begin
                column++;
                if (column == d)
                begin
                    column = 0;
                    if (d > 2)
                    begin
                        section  = SEC_MIDDLE;
                        row      = 8'd1;
                        row_base = IDX_W'(n);
                    end
                    else
                    begin
                        section  = SEC_BOTTOM;
                        row      = 8'(d - 1);
                        row_base = IDX_W'((d - 1) * n);
                    end
                end
            end
            else if (section == SEC_MIDDLE)
            begin
                if (!second_half)
                    second_half = 1'b1;
                else
                begin
                    second_half = 1'b0;
                    column++;
                    if (column == d)
                    begin
                        column = 0;
                        row++;
                        row_base = IDX_W'(row_base + n);
                        if (row + 1 == d)
                            section = SEC_BOTTOM;
                    end
                end
            end
            else
            begin
                column++;
                if (column == d)
                    go_home();
            end
        endfunction

        function void check_result(tri_t got, bit got_last);
            triangle_t t;
            if (pending_triangles.size() == 0)
            begin
                if (errors < 10)
                    $display("unexpected triangle %0d %0d %0d last %0b", got.first_index,
                             got.second_index, got.third_index, got_last);
                errors++;
                return;
            end
            t = pending_triangles.pop_front();
            checked++;
            if (got.third_index > top_index)
                top_index = got.third_index;
            if (got_last)
                sweeps++;
            if (got.first_index != t.corners.first_index
                || got.second_index != t.corners.second_index
                || got.third_index != t.corners.third_index || got_last != t.last)
            begin
                if (errors < 10)
                    $display("triangle %0d: expected %0d %0d %0d last %0b, got %0d %0d %0d last %0b",
                             checked, t.corners.first_index, t.corners.second_index,
                             t.corners.third_index, t.last, got.first_index, got.second_index,
                             got.third_index, got_last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    triangle_scoreboard sb = new();
    int tx_idle = 0;
    int rx_stall = 0;
    int cycles = 0;
    int settings_used = 0;

    sphere_index_generator_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= (rx_stall == 0) || ($urandom_range(99) >= rx_stall);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(tri_t'(m_axis_tdata), m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tdata[0]);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_request(bit restart);
        while ($urandom_range(99) < tx_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, restart};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (!sb.idle());
    endtask

    task automatic write_divisions(logic [7:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_divisions(value);
        settings_used++;
    endtask

    task automatic send_run(int count, int restart_pct);
        repeat (count)
            send_request($urandom_range(99) < restart_pct);
    endtask

    initial
    begin
        logic [7:0] div_pick;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        cfg_valid     <= 1'b0;
        cfg_data      <= 8'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default grid, restart in mid sweep
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        // smallest grid: top cap straight into bottom cap, then wrap
        write_divisions(8'd2);
        send_run(5, 0);
        write_divisions(8'd0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        write_divisions(8'd1);
        send_run(2, 0);
        // one middle row
        write_divisions(8'd3);
        send_run(13, 0);

        // largest grid: whole top cap and into the first middle row
        write_divisions(8'd255);
        send_run(260, 0);

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    tx_idle = 0;  rx_stall = 0;
                end
                1:
                begin
                    tx_idle = 70; rx_stall = 0;
                end
                2:
                begin
                    tx_idle = 0;  rx_stall = 70;
                end
                default:
                begin
                    tx_idle = 38; rx_stall = 38;
                end
            endcase
            case ($urandom_range(19))
                0, 1, 2: div_pick = 8'($urandom_range(1));
                3, 4, 5, 6, 7: div_pick = 8'($urandom_range(255));
                default: div_pick = 8'($urandom_range(8, 2));
            endcase
            write_divisions(div_pick);
            send_run(28, 4);
            if (phase == 1)
                wait_drained();
            send_run(28, 4);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        $display("checked %0d triangles over %0d divisions settings, %0d complete sweeps",
                 sb.checked, settings_used, sb.sweeps);
        $display("highest vertex index seen %0d, mismatches %0d", sb.top_index, sb.errors);
        if (sb.errors == 0 && sb.idle())
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
